### hdl/kbsc_pkg.sv
package kbsc_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int ADDR_W        = $clog2(TABLE_SIZE);
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_W         = MAX_KEY_BYTES * 8;
    localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
    localparam int KLEN_W        = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [1:0] {
        FUNC_ENCRYPT = 2'd0,
        FUNC_DECRYPT = 2'd1,
        FUNC_REBUILD = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    // Table lookup request from the stream side.
    typedef struct packed {
        logic              en;
        logic              inv;
        logic [ADDR_W-1:0] addr;
    } lookup_t;

endpackage

### hdl/kbsc_tables.sv
module kbsc_tables (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rebuild_start,
    input  logic [kbsc_pkg::KEY_W-1:0]          key,
    input  logic [kbsc_pkg::KIDX_W-1:0]         key_last_idx,
    input  kbsc_pkg::lookup_t                   lookup,
    output logic [kbsc_pkg::ADDR_W-1:0]         lookup_data,
    output logic                                busy
);

    localparam int AW = kbsc_pkg::ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_INV
    } state_t;

    state_t                           state_reg;
    logic [AW-1:0]                    i_reg;
    logic [AW-1:0]                    j_reg;
    logic [kbsc_pkg::KIDX_W-1:0]      k_reg;
    logic [AW-1:0]                    si_reg;
    logic [AW:0]                      cnt_reg;
    logic                             pend_reg;
    logic [AW-1:0]                    widx_reg;
    logic                             built_reg;
    logic                             lk_inv_reg;

    logic [AW-1:0] fwd_mem [kbsc_pkg::TABLE_SIZE];
    logic [AW-1:0] inv_mem [kbsc_pkg::TABLE_SIZE];
    logic [kbsc_pkg::TABLE_SIZE-1:0]  fwd_valid_reg;

    logic [AW-1:0] fwd_q_reg, fwd_raddr_reg, inv_q_reg, inv_raddr_reg;
    logic          fwd_rvalid_reg;

    logic          fwd_re, fwd_we, inv_re, inv_we;
    logic [AW-1:0] fwd_raddr, fwd_waddr, fwd_wdata, inv_raddr, inv_waddr, inv_wdata;
    logic [AW-1:0] fwd_rdata, inv_rdata, key_byte, j_sum;

    // An entry not written since the last rebuild still holds its identity value.
    assign fwd_rdata = fwd_rvalid_reg ? fwd_q_reg : fwd_raddr_reg;
    assign inv_rdata = built_reg ? inv_q_reg : inv_raddr_reg;
    assign key_byte  = key[k_reg*8 +: 8];
    assign j_sum     = AW'(j_reg + fwd_rdata + key_byte);

    assign busy        = (state_reg != ST_IDLE);
    assign lookup_data = lk_inv_reg ? inv_rdata : fwd_rdata;

    always_comb begin
        fwd_re    = 1'b0;
        fwd_raddr = lookup.addr;
        fwd_we    = 1'b0;
        fwd_waddr = i_reg;
        fwd_wdata = fwd_rdata;
        inv_re    = 1'b0;
        inv_raddr = lookup.addr;
        inv_we    = 1'b0;
        inv_waddr = fwd_rdata;
        inv_wdata = widx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                fwd_re = lookup.en && !lookup.inv;
                inv_re = lookup.en && lookup.inv;
            end
            ST_RD_I: begin
                fwd_re    = 1'b1;
                fwd_raddr = i_reg;
            end
            ST_RD_J: begin
                fwd_re    = 1'b1;
                fwd_raddr = j_sum;
            end
            ST_WR_I: begin
                fwd_we = 1'b1;
            end
            ST_WR_J: begin
                fwd_we    = 1'b1;
                fwd_waddr = j_reg;
                fwd_wdata = si_reg;
            end
            ST_INV: begin
                fwd_re    = !cnt_reg[AW];
                fwd_raddr = cnt_reg[AW-1:0];
                inv_we    = pend_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (fwd_we) begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (fwd_re) begin
            fwd_q_reg     <= fwd_mem[fwd_raddr];
            fwd_raddr_reg <= fwd_raddr;
        end
    end

    always_ff @(posedge aclk) begin
        if (inv_we) begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        if (inv_re) begin
            inv_q_reg     <= inv_mem[inv_raddr];
            inv_raddr_reg <= inv_raddr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg  <= '0;
            fwd_rvalid_reg <= 1'b0;
        end else begin
            if (fwd_re) begin
                fwd_rvalid_reg <= fwd_valid_reg[fwd_raddr];
            end
            if (rebuild_start) begin
                fwd_valid_reg <= '0;
            end else if (fwd_we) begin
                fwd_valid_reg[fwd_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            si_reg     <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            widx_reg   <= '0;
            built_reg  <= 1'b0;
            lk_inv_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (lookup.en) begin
                        lk_inv_reg <= lookup.inv;
                    end
                    if (rebuild_start) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_RD_I;
                    end
                end
                ST_RD_I: begin
                    state_reg <= ST_RD_J;
                end
                ST_RD_J: begin
                    si_reg    <= fwd_rdata;
                    j_reg     <= j_sum;
                    state_reg <= ST_WR_I;
                end
                ST_WR_I: begin
                    state_reg <= ST_WR_J;
                end
                ST_WR_J: begin
                    i_reg    <= AW'(i_reg + 1'b1);
                    k_reg    <= (k_reg == key_last_idx) ? '0 : k_reg + 1'b1;
                    pend_reg <= 1'b0;
                    cnt_reg  <= '0;
                    if (i_reg == AW'(kbsc_pkg::TABLE_SIZE - 1)) begin
                        state_reg <= ST_INV;
                    end else begin
                        state_reg <= ST_RD_I;
                    end
                end
                ST_INV: begin
                    // Reads of the forward table run one entry ahead of the inverse writes.
                    pend_reg <= !cnt_reg[AW];
                    widx_reg <= cnt_reg[AW-1:0];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg[AW]) begin
                        built_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_lookup_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        lookup.en |-> !busy)
        else $error("table lookup issued during rebuild");

    a_rebuild_enters_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rebuild_start |=> busy)
        else $error("rebuild command did not start the schedule");

    a_built_after_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy) |-> built_reg)
        else $error("rebuild finished without the inverse table built");

    a_single_port_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_we |-> !fwd_re)
        else $error("forward table read and written in the same cycle");
`endif

endmodule

### hdl/keyed_byte_substitution_cipher.sv
// Encrypt and decrypt beats: one table read, then the result moves through the read stage
// and the output register onto m_; one beat per cycle sustained while m_ is not stalled.
// Rebuild and no-op beats give a zero result the same way. After a rebuild beat the block
// accepts no beat until the key schedule (read i, read j, write i, write j per step on the
// forward table port) and then the inverse table fill are done. Synchronous active-low
// reset restores identity tables, a zero key and key length one.
module keyed_byte_substitution_cipher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  logic [1:0]                          s_tuser,   // [1:0] func
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kbsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kbsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = kbsc_pkg::ADDR_W;

    logic [kbsc_pkg::CFG_DATA_W-1:0]  key_low_reg, key_high_reg;
    logic [kbsc_pkg::KLEN_W-1:0]      key_len_reg;
    logic [kbsc_pkg::KLEN_W-1:0]      key_len_eff;
    logic [kbsc_pkg::KIDX_W-1:0]      key_last_idx;

    logic          p1_valid_reg, p1_zero_reg, p1_last_reg;
    logic          m_tvalid_reg, m_tlast_reg;
    logic [7:0]    m_tdata_reg;

    logic              s_accept, advance, tbl_busy, rebuild_start;
    kbsc_pkg::func_t   func;
    kbsc_pkg::lookup_t lookup;
    logic [AW-1:0]     lookup_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= kbsc_pkg::KLEN_W'(1);
        end else if (cfg_valid) begin
            unique case (kbsc_pkg::cfg_index_t'(cfg_index))
                kbsc_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                kbsc_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                kbsc_pkg::CFG_KEY_LEN:  key_len_reg  <= cfg_data[kbsc_pkg::KLEN_W-1:0];
                kbsc_pkg::CFG_UNUSED:   ;
                default: ;
            endcase
        end
    end

    // A length of zero acts as one, and lengths past the key size saturate.
    always_comb begin
        priority if (key_len_reg == '0) begin
            key_len_eff = kbsc_pkg::KLEN_W'(1);
        end else if (key_len_reg > kbsc_pkg::KLEN_W'(kbsc_pkg::MAX_KEY_BYTES)) begin
            key_len_eff = kbsc_pkg::KLEN_W'(kbsc_pkg::MAX_KEY_BYTES);
        end else begin
            key_len_eff = key_len_reg;
        end
    end
    assign key_last_idx = kbsc_pkg::KIDX_W'(key_len_eff - 1'b1);

    assign func          = kbsc_pkg::func_t'(s_tuser);
    assign advance       = !m_tvalid_reg || m_tready;
    assign s_tready      = !tbl_busy && (!p1_valid_reg || advance);
    assign s_accept      = s_tvalid && s_tready;
    assign rebuild_start = s_accept && (func == kbsc_pkg::FUNC_REBUILD);

    assign lookup.en   = s_accept &&
                         (func == kbsc_pkg::FUNC_ENCRYPT || func == kbsc_pkg::FUNC_DECRYPT);
    assign lookup.inv  = (func == kbsc_pkg::FUNC_DECRYPT);
    assign lookup.addr = s_tdata;

    kbsc_tables u_tables (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rebuild_start (rebuild_start),
        .key           ({key_high_reg, key_low_reg}),
        .key_last_idx  (key_last_idx),
        .lookup        (lookup),
        .lookup_data   (lookup_data),
        .busy          (tbl_busy)
    );

    // The read stage holds its beat while the output register is stalled; the table
    // read data stays put because no new read is issued in that time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_zero_reg  <= 1'b0;
            p1_last_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end else begin
            if (advance) begin
                m_tvalid_reg <= p1_valid_reg;
                m_tdata_reg  <= p1_zero_reg ? '0 : lookup_data;
                m_tlast_reg  <= p1_last_reg;
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
                p1_zero_reg  <= !lookup.en;
                p1_last_reg  <= s_tlast;
            end else if (advance) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_accept_needs_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !tbl_busy)
        else $error("beat accepted while tables rebuild");

    a_rebuild_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && p1_valid_reg && p1_zero_reg) |=> (m_tdata_reg == '0))
        else $error("rebuild or no-op beat gave a nonzero byte");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> p1_valid_reg)
        else $error("accepted beat lost in read stage");
`endif

endmodule

### tb/keyed_byte_substitution_cipher_tb.sv
`timescale 1ns / 100ps

module keyed_byte_substitution_cipher_tb;

    localparam int REBUILD_CYCLES = 1400;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ROUNDS  = 5;
    localparam int ROUND_BEATS    = 150;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } cipher_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = 8'd0;
    logic [1:0]                      s_tuser   = kbsc_pkg::FUNC_ENCRYPT;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [kbsc_pkg::CFG_IDX_W-1:0]  cfg_index = kbsc_pkg::CFG_KEY_LOW;
    logic [kbsc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the block state.
    logic [7:0]  fwd_table [kbsc_pkg::TABLE_SIZE];
    logic [7:0]  inv_table [kbsc_pkg::TABLE_SIZE];
    logic [63:0] key_low_reg  = '0;
    logic [63:0] key_high_reg = '0;
    logic [4:0]  key_len_reg  = 5'd1;

    cipher_result_t pending_results[$];
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int stall_mode      = 0;
    logic [6:0] pattern_timer = '0;

    keyed_byte_substitution_cipher u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // RC4 key schedule over the shadow key, then the inverse permutation.
    function automatic void rebuild_substitution_tables();
        logic [127:0] key_bits;
        int          key_count;
        logic [7:0]  j;
        logic [7:0]  swap_byte;
        key_bits  = {key_high_reg, key_low_reg};
        key_count = (key_len_reg == 5'd0) ? 1 :
                    (key_len_reg > kbsc_pkg::MAX_KEY_BYTES) ? kbsc_pkg::MAX_KEY_BYTES
                                                             : int'(key_len_reg);
        for (int i = 0; i < kbsc_pkg::TABLE_SIZE; i++) begin
            fwd_table[i] = 8'(i);
        end
        j = 8'd0;
        for (int i = 0; i < kbsc_pkg::TABLE_SIZE; i++) begin
            // Eight-bit arithmetic gives the modulo 256 for free.
            j = j + fwd_table[i] + key_bits[(i % key_count) * 8 +: 8];
            swap_byte    = fwd_table[i];
            fwd_table[i] = fwd_table[j];
            fwd_table[j] = swap_byte;
        end
        for (int i = 0; i < kbsc_pkg::TABLE_SIZE; i++) begin
            inv_table[fwd_table[i]] = 8'(i);
        end
    endfunction

    function automatic cipher_result_t predict_cipher_output(kbsc_pkg::func_t f,
                                                             logic [7:0] b, logic l);
        cipher_result_t r;
        r.out_byte = 8'd0;
        r.last     = l;
        case (f)
            kbsc_pkg::FUNC_ENCRYPT: r.out_byte = fwd_table[b];
            kbsc_pkg::FUNC_DECRYPT: r.out_byte = inv_table[b];
            kbsc_pkg::FUNC_REBUILD: rebuild_substitution_tables();
            default: ;
        endcase
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_beat(kbsc_pkg::func_t f, logic [7:0] b, logic l);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 32);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_cipher_output(f, b, l));
    endtask

    // Waits until every result is back and any rebuild has finished.
    task automatic drain_pipeline();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (REBUILD_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(kbsc_pkg::cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            kbsc_pkg::CFG_KEY_LOW:  key_low_reg  = value;
            kbsc_pkg::CFG_KEY_HIGH: key_high_reg = value;
            kbsc_pkg::CFG_KEY_LEN:  key_len_reg  = value[4:0];
            default: ;
        endcase
    endtask

    task automatic load_key(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word);
        drain_pipeline();
        write_register(kbsc_pkg::CFG_KEY_LOW, lo);
        write_register(kbsc_pkg::CFG_KEY_HIGH, hi);
        write_register(kbsc_pkg::CFG_KEY_LEN, len_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_identity_tables();
        send_beat(kbsc_pkg::FUNC_ENCRYPT, 8'h00, 1'b0);
        send_beat(kbsc_pkg::FUNC_ENCRYPT, 8'hFF, 1'b1);
        send_beat(kbsc_pkg::FUNC_DECRYPT, 8'h00, 1'b1);
        send_beat(kbsc_pkg::FUNC_DECRYPT, 8'hFF, 1'b0);
        send_beat(kbsc_pkg::FUNC_NOP, 8'hA5, 1'b1);
    endtask

    task automatic test_key_schedules();
        // Zero key with the reset length.
        send_beat(kbsc_pkg::FUNC_REBUILD, 8'h5A, 1'b0);
        send_beat(kbsc_pkg::FUNC_ENCRYPT, 8'h00, 1'b0);
        send_beat(kbsc_pkg::FUNC_DECRYPT, 8'hFF, 1'b1);
        // Longest key, all bits set.
        load_key('1, '1, 64'd16);
        send_beat(kbsc_pkg::FUNC_REBUILD, 8'hFF, 1'b1);
        send_beat(kbsc_pkg::FUNC_ENCRYPT, 8'hFF, 1'b1);
        send_beat(kbsc_pkg::FUNC_DECRYPT, 8'h00, 1'b0);
        // A length of zero behaves as a length of one.
        load_key({$urandom, $urandom}, {$urandom, $urandom}, 64'd0);
        send_beat(kbsc_pkg::FUNC_REBUILD, 8'h00, 1'b0);
        send_beat(kbsc_pkg::FUNC_ENCRYPT, 8'($urandom), 1'b1);
        // Lengths above sixteen saturate; upper data bits are not stored.
        load_key({$urandom, $urandom}, {$urandom, $urandom}, '1);
        send_beat(kbsc_pkg::FUNC_REBUILD, 8'h00, 1'b1);
        send_beat(kbsc_pkg::FUNC_DECRYPT, 8'($urandom), 1'b0);
        // Short key: the bytes beyond the length must not matter.
        load_key({$urandom, $urandom}, {$urandom, $urandom}, 64'd5);
        send_beat(kbsc_pkg::FUNC_REBUILD, 8'h00, 1'b0);
        send_beat(kbsc_pkg::FUNC_ENCRYPT, 8'($urandom), 1'b0);
        // A write to the unused index leaves the key alone.
        drain_pipeline();
        write_register(kbsc_pkg::CFG_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        send_beat(kbsc_pkg::FUNC_REBUILD, 8'h00, 1'b1);
        send_beat(kbsc_pkg::FUNC_DECRYPT, 8'($urandom), 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [63:0]     len_word;
        int              pick;
        kbsc_pkg::func_t f;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            len_word      = {$urandom, $urandom};
            len_word[4:0] = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(1, 16));
            load_key({$urandom, $urandom}, {$urandom, $urandom}, len_word);
            send_beat(kbsc_pkg::FUNC_REBUILD, 8'($urandom), 1'($urandom));
            for (int n = 0; n < ROUND_BEATS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2)       f = kbsc_pkg::FUNC_REBUILD;
                else if (pick < 5)  f = kbsc_pkg::FUNC_NOP;
                else if (pick < 52) f = kbsc_pkg::FUNC_ENCRYPT;
                else                f = kbsc_pkg::FUNC_DECRYPT;
                send_beat(f, 8'($urandom), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic test_output_backpressure();
        holds_requested++;
        // No sender gaps here, so the block backs up against the stall.
        burst_left = 64;
        for (int n = 0; n < 24; n++) begin
            send_beat(($urandom_range(0, 1) == 0) ? kbsc_pkg::FUNC_ENCRYPT
                                                  : kbsc_pkg::FUNC_DECRYPT,
                      8'($urandom), 1'($urandom));
        end
    endtask

    // Receiver: stall pattern changes each time the 7-bit pattern timer wraps, plus requested long holds.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_requested) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            if (pattern_timer == '0) begin
                stall_mode <= $urandom_range(0, 2);
            end
            pattern_timer <= pattern_timer + 1'b1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cipher_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("Unexpected beat: out_byte %02h last %0b", m_tdata, m_tlast);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.out_byte || m_tlast !== want.last) begin
                    if (mismatch_count < 10) begin
                        $display("Mismatch: out_byte exp %02h got %02h, last exp %0b got %0b",
                                 want.out_byte, m_tdata, want.last, m_tlast);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < kbsc_pkg::TABLE_SIZE; i++) begin
            fwd_table[i] = 8'(i);
            inv_table[i] = 8'(i);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity_tables();
        test_key_schedules();
        test_output_backpressure();
        test_random_traffic();
        drain_pipeline();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
